### rtl/byte_ring_buffer_macros.svh
// Assertion shorthands shared by the checkers of the byte ring buffer.
// All properties sample on the rising edge of clk and stay quiet during reset.
`ifndef BYTE_RING_BUFFER_MACROS_SVH
`define BYTE_RING_BUFFER_MACROS_SVH

// Same-cycle implication.
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/brb_pkg.sv
`default_nettype none
package brb_pkg;

  localparam int DEPTH  = 1024;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int DATA_W = 8;
  localparam int CNT_W  = 10;
  localparam int CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_PEEK      = 3'd2,
    CMD_ADV_FRONT = 3'd3,
    CMD_ADV_REAR  = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_t;

endpackage
`default_nettype wire

### rtl/brb_ram.sv
`default_nettype none
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read; rdata holds while not enabled.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/byte_ring_buffer.sv
`default_nettype none
// Byte ring buffer with one slot kept empty: DEPTH byte slots, at most DEPTH-1
// bytes held. Each input transaction carries one command (push, pop, peek,
// advance front, advance rear, clear) and produces exactly one result
// transaction with the byte read, a success flag and the used, free,
// contiguous-write and contiguous-read counts after the command. Bytes live
// in a single-port RAM with a registered read; the front and rear
// pointers are flip-flops updated when a transaction is accepted. Throughput
// is one transaction per cycle while out_ready holds; a result passes from
// the RAM access stage into the output register, which holds it while stalled.
// The RAM port is the only shared resource: push writes it, pop and peek
// read it, and since accesses are issued in order, at most one per cycle,
// a pop right after a push sees the byte just written. Advances wrap modulo
// DEPTH without checking the other pointer, and clear resets both pointers
// while leaving the stored bytes in place. Slots never written since reset
// read back as unknown data; only an advance of front or rear can expose them.
module byte_ring_buffer (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [brb_pkg::CMD_W-1:0] in_command,
  input  wire logic [brb_pkg::DATA_W-1:0] in_data_in,
  input  wire logic [brb_pkg::CNT_W-1:0] in_count,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [brb_pkg::DATA_W-1:0]     out_data_out,
  output logic                           out_ok,
  output logic [brb_pkg::CNT_W-1:0]      out_used_bytes,
  output logic [brb_pkg::CNT_W-1:0]      out_free_bytes,
  output logic [brb_pkg::CNT_W-1:0]      out_contiguous_write,
  output logic [brb_pkg::CNT_W-1:0]      out_contiguous_read
);

  import brb_pkg::*;

  // Pointer state
  logic [PTR_W-1:0] front_r, front_nxt;
  logic [PTR_W-1:0] rear_r, rear_nxt;

  // RAM access stage: the transaction waiting on read data
  logic p1_valid_r;
  logic p1_ok_r, p1_ok_nxt;
  logic p1_rd_r, p1_rd_nxt;

  // Output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_ok_r;
  logic [CNT_W-1:0]  out_used_r, out_free_r, out_cw_r, out_cr_r;

  // RAM port
  logic              ram_en, ram_we;
  logic [PTR_W-1:0]  ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  logic in_accept, p1_move;
  cmd_t cmd;

  logic [PTR_W-1:0] used_now, front_p1, rear_p1;
  logic [CNT_W-1:0] used_cnt, free_cnt, cw_cnt, cr_cnt;

  // Advance the access stage whenever the output register is free or draining.
  assign p1_move   = p1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !p1_valid_r || p1_move;
  assign in_accept = in_valid && in_ready;

  assign cmd      = cmd_t'(in_command);
  assign used_now = rear_r - front_r;
  assign front_p1 = front_r + PTR_W'(1);
  assign rear_p1  = rear_r + PTR_W'(1);

  // Command decode: pointer moves, RAM access and success flag.
  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = front_p1;
    p1_ok_nxt = 1'b0;
    p1_rd_nxt = 1'b0;
    case (cmd)
      CMD_PUSH: begin
        // Drop the byte when full.
        if (used_now != PTR_W'(DEPTH - 1)) begin
          rear_nxt  = rear_p1;
          ram_en    = in_accept;
          ram_we    = 1'b1;
          ram_addr  = rear_p1;
          p1_ok_nxt = 1'b1;
        end
      end
      CMD_POP: begin
        if (used_now != '0) begin
          front_nxt = front_p1;
          ram_en    = in_accept;
          ram_addr  = front_p1;
          p1_ok_nxt = 1'b1;
          p1_rd_nxt = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (in_count < CNT_W'(used_now)) begin
          ram_en    = in_accept;
          ram_addr  = front_p1 + PTR_W'(in_count);
          p1_ok_nxt = 1'b1;
          p1_rd_nxt = 1'b1;
        end
      end
      CMD_ADV_FRONT: front_nxt = front_r + PTR_W'(in_count);
      CMD_ADV_REAR:  rear_nxt  = rear_r + PTR_W'(in_count);
      CMD_CLEAR: begin
        front_nxt = '0;
        rear_nxt  = '0;
      end
      default: ;
    endcase
  end

  brb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_data_in),
    .rdata(ram_rdata)
  );

  // Occupancy figures from the pointers as the transaction in the access
  // stage left them; a newly accepted transaction only moves them at the edge.
  always_comb begin
    used_cnt = CNT_W'(used_now);
    free_cnt = CNT_W'(PTR_W'(DEPTH - 1) - used_now);
    if (rear_p1 == front_r) begin
      cw_cnt = '0;
    end else if (rear_p1 < front_r) begin
      cw_cnt = CNT_W'(front_r - rear_p1);
    end else begin
      cw_cnt = CNT_W'((PTR_W+1)'(DEPTH) - {1'b0, rear_p1});
    end
    if (front_r == rear_r) begin
      cr_cnt = '0;
    end else if (front_p1 <= rear_r) begin
      cr_cnt = CNT_W'(rear_r - front_r);
    end else begin
      cr_cnt = CNT_W'((PTR_W+1)'(DEPTH) - {1'b0, front_p1});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      rear_r      <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        front_r <= front_nxt;
        rear_r  <= rear_nxt;
      end
      if (in_accept) begin
        p1_valid_r <= 1'b1;
      end else if (p1_move) begin
        p1_valid_r <= 1'b0;
      end
      if (p1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_ok_r <= p1_ok_nxt;
      p1_rd_r <= p1_rd_nxt;
    end
    if (p1_move) begin
      out_data_r <= p1_rd_r ? ram_rdata : '0;
      out_ok_r   <= p1_ok_r;
      out_used_r <= used_cnt;
      out_free_r <= free_cnt;
      out_cw_r   <= cw_cnt;
      out_cr_r   <= cr_cnt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data_out         = out_data_r;
  assign out_ok               = out_ok_r;
  assign out_used_bytes       = out_used_r;
  assign out_free_bytes       = out_free_r;
  assign out_contiguous_write = out_cw_r;
  assign out_contiguous_read  = out_cr_r;

endmodule
`default_nettype wire

### rtl/brb_checker.sv
`default_nettype none
`include "byte_ring_buffer_macros.svh"
module brb_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [brb_pkg::CMD_W-1:0]  in_command,
  input wire logic [brb_pkg::DATA_W-1:0] in_data_in,
  input wire logic [brb_pkg::CNT_W-1:0]  in_count,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [brb_pkg::DATA_W-1:0] out_data_out,
  input wire logic                       out_ok,
  input wire logic [brb_pkg::CNT_W-1:0]  out_used_bytes,
  input wire logic [brb_pkg::CNT_W-1:0]  out_free_bytes,
  input wire logic [brb_pkg::CNT_W-1:0]  out_contiguous_write,
  input wire logic [brb_pkg::CNT_W-1:0]  out_contiguous_read
);

  import brb_pkg::*;

  `BRB_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(in_command) && $stable(in_data_in) && $stable(in_count),
    "input transaction withdrawn or changed while waiting")

  `BRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_data_out) && $stable(out_used_bytes),
    "result dropped or changed while stalled")

  `BRB_ASSERT_NOW(a_used_free_sum, out_valid,
    ({1'b0, out_used_bytes} + {1'b0, out_free_bytes}) == (CNT_W+1)'(DEPTH - 1),
    "used plus free does not cover the buffer")

  `BRB_ASSERT_NOW(a_fail_zero_data, out_valid && !out_ok, out_data_out == '0,
    "failed transaction returned data")

  `BRB_ASSERT_NOW(a_contig_bounds, out_valid,
    out_contiguous_read <= out_used_bytes && out_contiguous_write <= out_free_bytes,
    "contiguous span exceeds occupancy")

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_command          (in_command),
  .in_data_in          (in_data_in),
  .in_count            (in_count),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_data_out        (out_data_out),
  .out_ok              (out_ok),
  .out_used_bytes      (out_used_bytes),
  .out_free_bytes      (out_free_bytes),
  .out_contiguous_write(out_contiguous_write),
  .out_contiguous_read (out_contiguous_read)
);
`default_nettype wire

### tb/byte_ring_buffer_tb.sv
`default_nettype none
module byte_ring_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brb_pkg::*;

  // Command codes that the package leaves undefined; the block must treat them as no-ops.
  localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

  localparam int NUM_ITEMS   = 1750;
  localparam int DRAIN_TAIL  = 12;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              ok;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
    logic [CNT_W-1:0]  cont_wr;
    logic [CNT_W-1:0]  cont_rd;
  } ring_result_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_JUMP} run_mode_t;

  // Shadow ring: tracks pointers, stored bytes and which slots were ever written,
  // and queues the result each accepted command must produce.
  class ring_scoreboard;
    bit [DATA_W-1:0] slot_data[DEPTH];
    bit              slot_written[DEPTH];
    int unsigned     front_ptr;
    int unsigned     rear_ptr;
    ring_result_t    expected_q[$];
    int unsigned     faults;

    function new();
      front_ptr = 0;
      rear_ptr  = 0;
      faults    = 0;
      foreach (slot_written[i]) slot_written[i] = 1'b0;
    endfunction

    function int unsigned held();
      return (rear_ptr + DEPTH - front_ptr) % DEPTH;
    endfunction

    function int unsigned room();
      return DEPTH - 1 - held();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // True when the byte at this offset past the oldest one holds pushed data.
    function bit can_read(int unsigned offset);
      return slot_written[(front_ptr + 1 + offset) % DEPTH];
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] din,
                               logic [CNT_W-1:0] cnt);
      ring_result_t r;
      int unsigned  nxt;
      int unsigned  used;
      r.data = '0;
      r.ok   = 1'b0;
      case (cmd)
        CMD_PUSH: begin
          if (room() != 0) begin
            rear_ptr = (rear_ptr + 1) % DEPTH;
            slot_data[rear_ptr]    = din;
            slot_written[rear_ptr] = 1'b1;
            r.ok = 1'b1;
          end
        end
        CMD_POP: begin
          if (held() != 0) begin
            front_ptr = (front_ptr + 1) % DEPTH;
            r.data = slot_data[front_ptr];
            r.ok   = 1'b1;
          end
        end
        CMD_PEEK: begin
          if (cnt < held()) begin
            r.data = slot_data[(front_ptr + 1 + cnt) % DEPTH];
            r.ok   = 1'b1;
          end
        end
        CMD_ADV_FRONT: front_ptr = (front_ptr + cnt) % DEPTH;
        CMD_ADV_REAR:  rear_ptr  = (rear_ptr + cnt) % DEPTH;
        CMD_CLEAR: begin
          front_ptr = 0;
          rear_ptr  = 0;
        end
        default: ;
      endcase
      used   = held();
      r.used = CNT_W'(used);
      r.free = CNT_W'(DEPTH - 1 - used);
      nxt = (rear_ptr + 1) % DEPTH;
      if (nxt == front_ptr) r.cont_wr = '0;
      else if (nxt < front_ptr) r.cont_wr = CNT_W'(front_ptr - nxt);
      else r.cont_wr = CNT_W'(DEPTH - nxt);
      if (front_ptr == rear_ptr) begin
        r.cont_rd = '0;
      end else begin
        nxt = (front_ptr + 1) % DEPTH;
        r.cont_rd = (nxt <= rear_ptr) ? CNT_W'(rear_ptr - nxt + 1) : CNT_W'(DEPTH - nxt);
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (expected_q.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("unexpected result: data %02h ok %0d used %0d free %0d cw %0d cr %0d",
                   got.data, got.ok, got.used, got.free, got.cont_wr, got.cont_rd);
        return;
      end
      want = expected_q.pop_front();
      if (got.data !== want.data || got.ok !== want.ok || got.used !== want.used ||
          got.free !== want.free || got.cont_wr !== want.cont_wr ||
          got.cont_rd !== want.cont_rd) begin
        faults++;
        if (faults <= MAX_REPORTS) begin
          $display("mismatch: expected data %02h ok %0d used %0d free %0d cw %0d cr %0d",
                   want.data, want.ok, want.used, want.free, want.cont_wr, want.cont_rd);
          $display("          actual   data %02h ok %0d used %0d free %0d cw %0d cr %0d",
                   got.data, got.ok, got.used, got.free, got.cont_wr, got.cont_rd);
        end
      end
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command = '0;
  logic [DATA_W-1:0] in_data_in = '0;
  logic [CNT_W-1:0]  in_count   = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [DATA_W-1:0] out_data_out;
  logic              out_ok;
  logic [CNT_W-1:0]  out_used_bytes;
  logic [CNT_W-1:0]  out_free_bytes;
  logic [CNT_W-1:0]  out_contiguous_write;
  logic [CNT_W-1:0]  out_contiguous_read;

  ring_scoreboard book;
  int unsigned    sent       = 0;
  int unsigned    burst_left = 0;

  // Receiver stall state: a mode and an 8-bit ready pattern, both reshuffled now and then.
  int unsigned    stall_mode  = 0;
  int unsigned    stall_left  = 0;
  logic [7:0]     stall_pat   = 8'hff;

  byte_ring_buffer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_data_in           (in_data_in),
    .in_count             (in_count),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data_out         (out_data_out),
    .out_ok               (out_ok),
    .out_used_bytes       (out_used_bytes),
    .out_free_bytes       (out_free_bytes),
    .out_contiguous_write (out_contiguous_write),
    .out_contiguous_read  (out_contiguous_read)
  );

  always #5 clk = ~clk;

  // Receiver: pick a stall style for a stretch of cycles, then apply it every edge.
  // Style 0 never stalls, 1 replays a rotating pattern, 2 is a coin flip, 3 mostly stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_pat  = 8'($urandom_range(1, 255));
      stall_left = $urandom_range(32, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: begin
        out_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Result monitor: check every accepted result transaction against the oldest prediction.
  always @(posedge clk) begin
    ring_result_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.data    = out_data_out;
      seen.ok      = out_ok;
      seen.used    = out_used_bytes;
      seen.free    = out_free_bytes;
      seen.cont_wr = out_contiguous_write;
      seen.cont_rd = out_contiguous_read;
      book.check_result(seen);
    end
  end

  // Present one command, hold it until the handshake completes, then record it.
  // Bursts end with a random gap, with valid dropped for the gap only.
  task automatic drive(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] din,
                       input logic [CNT_W-1:0] cnt);
    int unsigned gap;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_data_in <= din;
    in_count   <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_command(cmd, din, cnt);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Hold the input side idle until every predicted result has been seen.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Build one random command in the given mode. Never let a pop or peek land on a slot
  // that has not been pushed since reset: swap such a read for a push.
  task automatic next_random(input run_mode_t mode);
    int unsigned      r;
    int unsigned      used;
    int unsigned      c_push, c_pop, c_peek, c_advf, c_advr, c_clr;
    logic [CMD_W-1:0] cmd;
    logic [DATA_W-1:0] din;
    logic [CNT_W-1:0] cnt;
    case (mode)
      MODE_FILL:  {c_push, c_pop, c_peek, c_advf, c_advr, c_clr} = {32'd85, 32'd90, 32'd99,
                                                                    32'd99, 32'd99, 32'd99};
      MODE_DRAIN: {c_push, c_pop, c_peek, c_advf, c_advr, c_clr} = {32'd12, 32'd77, 32'd92,
                                                                    32'd95, 32'd97, 32'd98};
      MODE_MIX:   {c_push, c_pop, c_peek, c_advf, c_advr, c_clr} = {32'd35, 32'd65, 32'd85,
                                                                    32'd89, 32'd93, 32'd96};
      default:    {c_push, c_pop, c_peek, c_advf, c_advr, c_clr} = {32'd20, 32'd40, 32'd60,
                                                                    32'd75, 32'd90, 32'd95};
    endcase
    used = book.held();
    din  = DATA_W'($urandom_range(0, 255));
    cnt  = CNT_W'($urandom_range(0, 1023));
    r    = $urandom_range(0, 99);
    if (r < c_push) cmd = CMD_PUSH;
    else if (r < c_pop) cmd = CMD_POP;
    else if (r < c_peek) cmd = CMD_PEEK;
    else if (r < c_advf) cmd = CMD_ADV_FRONT;
    else if (r < c_advr) cmd = CMD_ADV_REAR;
    else if (r < c_clr) cmd = CMD_CLEAR;
    else cmd = $urandom_range(0, 1) ? CMD_RESERVED_HI : CMD_RESERVED_LO;

    // Bias peek offsets toward the occupied range and its edge; bias steps toward
    // tiny moves and near-full-circle wraps.
    if (cmd == CMD_PEEK && used > 0 && $urandom_range(0, 3) != 0)
      cnt = CNT_W'($urandom_range(0, used));
    if (cmd == CMD_ADV_FRONT || cmd == CMD_ADV_REAR) begin
      case ($urandom_range(0, 3))
        0: cnt = CNT_W'($urandom_range(0, 4));
        1: cnt = CNT_W'(1023 - $urandom_range(0, 4));
        default: ;
      endcase
    end

    if (cmd == CMD_POP && used > 0 && !book.can_read(0)) cmd = CMD_PUSH;
    if (cmd == CMD_PEEK && cnt < used && !book.can_read(cnt)) cmd = CMD_PUSH;
    drive(cmd, din, cnt);
  endtask

  initial begin
    run_mode_t   mode;
    int unsigned phase;
    book = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ring: pop and peek must miss.
    drive(CMD_POP, 8'h00, 10'd0);
    drive(CMD_PEEK, 8'h00, 10'd0);
    // Two bytes at the data extremes, peek inside, at the edge and far past it.
    drive(CMD_PUSH, 8'h00, 10'd0);
    drive(CMD_PUSH, 8'hff, 10'd1023);
    drive(CMD_PEEK, 8'h00, 10'd1);
    drive(CMD_PEEK, 8'h00, 10'd2);
    drive(CMD_PEEK, 8'h00, 10'd1023);
    drive(CMD_POP, 8'h00, 10'd0);
    // Zero-step advances, then clear with a byte still held.
    drive(CMD_ADV_FRONT, 8'h00, 10'd0);
    drive(CMD_ADV_REAR, 8'h00, 10'd0);
    drive(CMD_CLEAR, 8'h00, 10'd0);
    // Front one ahead of rear reads as full: the push must be dropped.
    drive(CMD_ADV_FRONT, 8'h00, 10'd1);
    drive(CMD_PUSH, 8'ha5, 10'd0);
    // Reserved command codes change nothing.
    drive(CMD_RESERVED_LO, 8'hff, 10'd1023);
    drive(CMD_RESERVED_HI, 8'h00, 10'd0);
    drive(CMD_CLEAR, 8'h00, 10'd0);
    // Rear at the top slot with front at zero: full by advance, no reads.
    drive(CMD_ADV_REAR, 8'h00, 10'd1023);
    drive(CMD_CLEAR, 8'h00, 10'd0);
    // Wrap: park both pointers near the top, push across the wrap point, read back.
    drive(CMD_ADV_FRONT, 8'h00, 10'd1021);
    drive(CMD_ADV_REAR, 8'h00, 10'd1021);
    drive(CMD_PUSH, 8'h5a, 10'd0);
    drive(CMD_PUSH, 8'hc3, 10'd0);
    drive(CMD_PUSH, 8'h3c, 10'd0);
    drive(CMD_PUSH, 8'h81, 10'd0);
    drive(CMD_PEEK, 8'h00, 10'd3);
    drive(CMD_POP, 8'h00, 10'd0);
    pause_until_drained();

    // Fill to the brim with real data, then keep pushing into the full ring.
    while (book.room() != 0 && sent < 1400) next_random(MODE_FILL);
    repeat (20) next_random(MODE_FILL);
    pause_until_drained();

    // Alternate drain, mixed and pointer-jumping phases for the rest.
    while (sent < NUM_ITEMS) begin
      mode  = run_mode_t'($urandom_range(1, 3));
      phase = $urandom_range(30, 150);
      while (phase > 0 && sent < NUM_ITEMS) begin
        next_random(mode);
        phase--;
      end
    end

    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (book.faults == 0 && book.pending() == 0)
      $display("byte_ring_buffer regression: pass");
    else
      $display("byte_ring_buffer regression: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("byte_ring_buffer regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
